// ===== rtl/assert_macros.svh =====
// assertion macros shared by the wheel power limiter modules
// expects a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/wpl_pkg.sv =====
// types and constants of the wheel power limiter
// used by wpl_alu and wheel_power_limiter_top
package wpl_pkg;

  // serial arithmetic unit widths
  localparam int ALU_AW     = 96;
  localparam int ALU_BW     = 64;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 48;
  localparam int CNT_W      = 7;

  // configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;
  localparam logic [CFG_IW-1:0] CFG_TORQUE      = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_STEER       = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_COPPER      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SPEED_LOSS  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_STATIC      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_CLAMP       = 3'd5;

  // derating divisor for low buffer energy
  localparam logic [7:0] LOW_ENERGY_DIV = 8'd20;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  // magnitude of a 16-bit signed value
  function automatic logic [15:0] abs16(input logic [15:0] x);
    abs16 = x[15] ? 16'(-x) : x;
  endfunction

endpackage

// ===== rtl/wpl_alu.sv =====
// serial arithmetic unit: radix-16 multiply, restoring divide, bitwise square root
// depends on wpl_pkg and assert_macros.svh
`include "assert_macros.svh"

module wpl_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  wpl_pkg::alu_ctl_t          ctl,
  input  logic [wpl_pkg::ALU_AW-1:0] opa,
  input  logic [wpl_pkg::ALU_BW-1:0] opb,
  output logic [wpl_pkg::ALU_AW-1:0] res,
  output logic                       done
);
  import wpl_pkg::*;

  logic              busy;
  alu_op_t           op_r;
  logic [ALU_AW-1:0] acc;
  logic [ALU_AW-1:0] ra;
  logic [ALU_BW-1:0] rb;
  logic [CNT_W-1:0]  cnt;

  logic [ALU_AW-1:0] mul_part;
  logic [64:0]       div_rem;
  logic              div_ge;
  logic [51:0]       sq_rem;
  logic [51:0]       sq_trial;
  logic              sq_ge;
  logic              last_step;

  // per-step datapath
  always_comb begin
    mul_part = ALU_AW'(ra * {{(ALU_AW-4){1'b0}}, rb[3:0]});
    div_rem  = {acc[63:0], ra[63]};
    div_ge   = div_rem >= {1'b0, rb};
    sq_rem   = {acc[49:0], ra[ALU_AW-1 -: 2]};
    sq_trial = {2'b00, rb[47:0], 2'b01};
    sq_ge    = sq_rem >= sq_trial;
    case (op_r)
      OP_MUL:          last_step = (rb[ALU_BW-1:4] == '0);
      OP_DIV, OP_SQRT: last_step = (cnt == CNT_W'(1));
      default:         last_step = 1'b1;
    endcase
  end

  // sequencing of one operation
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !ctl.start && busy && last_step;
      if (ctl.start) begin
        busy <= 1'b1;
        op_r <= ctl.op;
        acc  <= '0;
        ra   <= opa;
        rb   <= (ctl.op == OP_SQRT) ? '0 : opb;
        cnt  <= (ctl.op == OP_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy) begin
        if (last_step) busy <= 1'b0;
        case (op_r)
          OP_MUL: begin
            acc <= acc + mul_part;
            ra  <= ra << 4;
            rb  <= rb >> 4;
          end
          OP_DIV: begin
            acc <= div_ge ? ALU_AW'(div_rem - {1'b0, rb}) : ALU_AW'(div_rem[63:0]);
            ra  <= {ra[ALU_AW-1:64], ra[62:0], div_ge};
            cnt <= cnt - 1'b1;
          end
          OP_SQRT: begin
            acc <= sq_ge ? ALU_AW'(sq_rem - sq_trial) : ALU_AW'(sq_rem);
            ra  <= ra << 2;
            rb  <= {16'b0, rb[46:0], sq_ge};
            cnt <= cnt - 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // result select
  always_comb begin
    case (op_r)
      OP_MUL:  res = acc;
      OP_DIV:  res = {32'b0, ra[63:0]};
      OP_SQRT: res = {48'b0, rb[47:0]};
      default: res = '0;
    endcase
  end

  `ASSERT_IMPLIES(a_start_when_free, ctl.start, !busy)
  `ASSERT_NEXT(a_done_single, done, !done)
  `ASSERT_IMPLIES(a_done_released, done, !busy)

endmodule

// ===== rtl/wheel_power_limiter_top.sv =====
// wheel power limiter: per-wheel power estimate, quadratic current solve, derating
// each item runs eight radix-16 multiplies in wpl_alu; when limiting, the closing
// item then runs per wheel two 64-step divides (the second skipped for a zero
// copper coefficient), a 48-step square root and an optional 64-step derate divide
// throughput: one item at a time, one result per wheel in order
// reset: synchronous, clears the wheel count, the total and the output valid
`include "assert_macros.svh"

module wheel_power_limiter_top #(
  parameter int WHEELS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [15:0]         drive_current,
  input  logic signed [15:0]         drive_speed,
  input  logic signed [15:0]         steer_current,
  input  logic signed [15:0]         steer_speed,
  input  logic [7:0]                 power_limit,
  input  logic [7:0]                 reserve_energy,
  input  logic                       wheel_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 wheel_index,
  output logic signed [15:0]         limited_current,
  output logic                       result_last,
  input  logic                       cfg_write,
  input  logic [wpl_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wpl_pkg::CFG_DW-1:0] cfg_data
);
  import wpl_pkg::*;

  localparam int IW = (WHEELS > 1) ? $clog2(WHEELS) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_CLOSE = 6'b000100,
    S_LOAD  = 6'b001000,
    S_DER   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [17:0] {
    SP_CS    = 18'h00001,
    SP_KT    = 18'h00002,
    SP_SS    = 18'h00004,
    SP_K2    = 18'h00008,
    SP_CC    = 18'h00010,
    SP_KA    = 18'h00020,
    SP_XS    = 18'h00040,
    SP_KS    = 18'h00080,
    SP_PROD  = 18'h00100,
    SP_SCALE = 18'h00200,
    SP_WSS   = 18'h00400,
    SP_WK2   = 18'h00800,
    SP_B     = 18'h01000,
    SP_BSQ   = 18'h02000,
    SP_FAC   = 18'h04000,
    SP_SQRT  = 18'h08000,
    SP_QUOT  = 18'h10000,
    SP_DER20 = 18'h20000
  } step_t;

  // configuration registers
  logic [23:0] torque_coefficient;
  logic [23:0] steer_torque_coefficient;
  logic [23:0] copper_loss_coefficient;
  logic [23:0] speed_loss_coefficient;
  logic [15:0] static_power;
  logic [14:0] current_clamp;

  // sequencer and working registers
  state_t              state;
  step_t               step;
  logic                issued;
  logic [IW-1:0]       wheel_count;
  logic [IW-1:0]       k;
  logic [IW-1:0]       nlast_r;
  logic                over_r;
  logic [15:0]         cur_r;
  logic [15:0]         spd_r;
  logic [15:0]         scur_r;
  logic [15:0]         sspd_r;
  logic [7:0]          limit_r;
  logic [7:0]          energy_r;
  logic                last_r;
  logic [ALU_AW-1:0]   m_r;
  logic signed [59:0]  acc_r;
  logic signed [39:0]  pw_r;
  logic signed [47:0]  total_r;
  logic [39:0]         scaled_r;
  logic [59:0]         c_r;
  logic [39:0]         bmag_r;
  logic [79:0]         bsq_r;
  logic [49:0]         num_r;
  logic [15:0]         cmag;
  logic                cneg;

  // per-wheel stores
  logic [15:0] current_store [WHEELS];
  logic [15:0] speed_store [WHEELS];
  logic [39:0] wheel_power_store [WHEELS];

  // arithmetic unit
  alu_ctl_t          alu_ctl;
  logic [ALU_AW-1:0] alu_a;
  logic [ALU_BW-1:0] alu_b;
  logic [ALU_AW-1:0] alu_res;
  logic              alu_done;

  logic [15:0]        cur_mag, spd_mag, scur_mag, sspd_mag;
  logic [39:0]        pw_mag;
  logic [59:0]        c_mag;
  logic [49:0]        num_mag;
  logic               skip_quot;
  logic               out_free;
  logic signed [59:0] acc_bias;
  logic signed [39:0] pw_new;
  logic [59:0]        term60;
  logic [47:0]        steer48;
  logic [86:0]        d_sum;
  logic [86:0]        d_diff;
  logic               c_le0;
  logic [49:0]        bneg50;
  logic [49:0]        s50;
  logic               cur_pos;

  wpl_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .opa  (alu_a),
    .opb  (alu_b),
    .res  (alu_res),
    .done (alu_done)
  );

  // magnitudes and derived terms
  always_comb begin
    cur_mag  = abs16(cur_r);
    spd_mag  = abs16(spd_r);
    scur_mag = abs16(scur_r);
    sspd_mag = abs16(sspd_r);
    pw_mag   = pw_r[39] ? 40'(-pw_r) : 40'(pw_r);
    c_mag    = c_r[59] ? 60'(-c_r) : c_r;
    num_mag  = num_r[49] ? 50'(-num_r) : num_r;
    acc_bias = acc_r + $signed({36'b0, {24{acc_r[59]}}});
    pw_new   = 40'(acc_bias[59:24]) | {{4{acc_bias[59]}}, 36'b0};
    term60   = 60'(alu_res[58:0]);
    steer48  = (scur_r[15] ^ sspd_r[15]) ? 48'(-48'(alu_res[54:24]))
                                         : 48'(alu_res[54:24]);
    d_sum    = 87'(bsq_r) + 87'(alu_res[85:0]);
    d_diff   = 87'(bsq_r) - 87'(alu_res[85:0]);
    c_le0    = c_r[59] || (c_r == '0);
    bneg50   = spd_r[15] ? 50'(bmag_r) : 50'(-50'(bmag_r));
    s50      = 50'(alu_res[47:0]);
    cur_pos  = !cur_r[15] && (cur_r != '0);
    skip_quot = (step == SP_QUOT) && (copper_loss_coefficient == '0);
    out_free = !out_valid || out_ready;
    in_ready = (state == S_IDLE);
  end

  // operand select per step
  always_comb begin
    alu_a      = '0;
    alu_b      = '0;
    alu_ctl.op = OP_MUL;
    case (step)
      SP_CS:    begin alu_a = ALU_AW'(cur_mag);  alu_b = ALU_BW'(spd_mag);  end
      SP_KT:    begin alu_a = m_r; alu_b = ALU_BW'(torque_coefficient);       end
      SP_SS:    begin alu_a = ALU_AW'(spd_mag);  alu_b = ALU_BW'(spd_mag);  end
      SP_K2:    begin alu_a = m_r; alu_b = ALU_BW'(speed_loss_coefficient);   end
      SP_CC:    begin alu_a = ALU_AW'(cur_mag);  alu_b = ALU_BW'(cur_mag);  end
      SP_KA:    begin alu_a = m_r; alu_b = ALU_BW'(copper_loss_coefficient);  end
      SP_XS:    begin alu_a = ALU_AW'(scur_mag); alu_b = ALU_BW'(sspd_mag); end
      SP_KS:    begin alu_a = m_r; alu_b = ALU_BW'(steer_torque_coefficient); end
      SP_PROD:  begin alu_a = ALU_AW'(pw_mag); alu_b = ALU_BW'({limit_r, 16'b0}); end
      SP_SCALE: begin
        alu_ctl.op = OP_DIV;
        alu_a = m_r;
        alu_b = ALU_BW'(total_r);
      end
      SP_WSS:   begin alu_a = ALU_AW'(spd_mag); alu_b = ALU_BW'(spd_mag); end
      SP_WK2:   begin alu_a = m_r; alu_b = ALU_BW'(speed_loss_coefficient); end
      SP_B:     begin alu_a = ALU_AW'(torque_coefficient); alu_b = ALU_BW'(spd_mag); end
      SP_BSQ:   begin alu_a = ALU_AW'(bmag_r); alu_b = ALU_BW'(bmag_r); end
      SP_FAC:   begin
        alu_a = ALU_AW'(c_mag);
        alu_b = ALU_BW'({copper_loss_coefficient, 2'b00});
      end
      SP_SQRT:  begin alu_ctl.op = OP_SQRT; alu_a = m_r; end
      SP_QUOT:  begin
        alu_ctl.op = OP_DIV;
        alu_a = ALU_AW'(num_mag);
        alu_b = ALU_BW'({copper_loss_coefficient, 1'b0});
      end
      SP_DER20: begin
        alu_ctl.op = OP_DIV;
        alu_a = ALU_AW'(cmag);
        alu_b = ALU_BW'(LOW_ENERGY_DIV);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
    alu_ctl.start = (state == S_RUN) && !issued && !skip_quot;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      torque_coefficient       <= 24'd2195600;
      steer_torque_coefficient <= 24'd10236450;
      copper_loss_coefficient  <= 24'd135240;
      speed_loss_coefficient   <= 24'd159759;
      static_power             <= 16'd1173;
      current_clamp            <= 15'd16000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TORQUE:     torque_coefficient       <= cfg_data;
        CFG_STEER:      steer_torque_coefficient <= cfg_data;
        CFG_COPPER:     copper_loss_coefficient  <= cfg_data;
        CFG_SPEED_LOSS: speed_loss_coefficient   <= cfg_data;
        CFG_STATIC:     static_power             <= cfg_data[15:0];
        CFG_CLAMP:      current_clamp            <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // per-wheel stores, written once the drive power is known
  always_ff @(posedge clk) begin
    if (state == S_RUN && issued && alu_done && step == SP_XS) begin
      current_store[wheel_count]     <= cur_r;
      speed_store[wheel_count]       <= spd_r;
      wheel_power_store[wheel_count] <= pw_new;
    end
  end

  // output valid: set when a result is loaded, cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= SP_CS;
      issued      <= 1'b0;
      wheel_count <= '0;
      total_r     <= '0;
      k           <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_r    <= drive_current;
            spd_r    <= drive_speed;
            scur_r   <= steer_current;
            sspd_r   <= steer_speed;
            limit_r  <= power_limit;
            energy_r <= reserve_energy;
            last_r   <= wheel_last;
            step     <= SP_CS;
            issued   <= 1'b0;
            state    <= S_RUN;
          end
        end
        S_RUN: begin
          if (!issued) begin
            if (skip_quot) begin
              // zero copper coefficient saturates by the sign of the numerator
              cmag  <= (num_r != '0) ? 16'(current_clamp) : 16'd0;
              cneg  <= num_r[49];
              state <= S_DER;
            end else begin
              issued <= 1'b1;
            end
          end else if (alu_done) begin
            issued <= 1'b0;
            case (step)
              SP_CS: begin m_r <= alu_res; step <= SP_KT; end
              SP_KT: begin
                acc_r <= $signed((60'(static_power) << 32)
                         + ((cur_r[15] ^ spd_r[15]) ? 60'(-term60) : term60));
                step <= SP_SS;
              end
              SP_SS: begin m_r <= alu_res; step <= SP_K2; end
              SP_K2: begin acc_r <= acc_r + $signed(term60); step <= SP_CC; end
              SP_CC: begin m_r <= alu_res; step <= SP_KA; end
              SP_KA: begin acc_r <= acc_r + $signed(term60); step <= SP_XS; end
              SP_XS: begin
                m_r  <= alu_res;
                pw_r <= pw_new;
                step <= SP_KS;
              end
              SP_KS: begin
                total_r <= total_r + 48'(pw_r) + $signed(steer48);
                if (last_r || wheel_count == IW'(WHEELS - 1)) begin
                  nlast_r <= wheel_count;
                  state   <= S_CLOSE;
                end else begin
                  wheel_count <= wheel_count + 1'b1;
                  state       <= S_IDLE;
                end
              end
              SP_PROD:  begin m_r <= alu_res; step <= SP_SCALE; end
              SP_SCALE: begin scaled_r <= alu_res[39:0]; step <= SP_WSS; end
              SP_WSS:   begin m_r <= alu_res; step <= SP_WK2; end
              SP_WK2: begin
                c_r  <= term60 + (60'(static_power) << 32) - (60'(scaled_r) << 24);
                step <= SP_B;
              end
              SP_B:   begin bmag_r <= alu_res[39:0]; step <= SP_BSQ; end
              SP_BSQ: begin bsq_r <= alu_res[79:0]; step <= SP_FAC; end
              SP_FAC: begin
                // negative discriminant is taken as zero
                if (c_le0) m_r <= ALU_AW'(d_sum);
                else if (!d_diff[86]) m_r <= ALU_AW'(d_diff);
                else m_r <= '0;
                step <= SP_SQRT;
              end
              SP_SQRT: begin
                num_r <= cur_pos ? bneg50 + s50 : bneg50 - s50;
                step  <= SP_QUOT;
              end
              SP_QUOT: begin
                cmag  <= (alu_res[63:0] > 64'(current_clamp)) ? 16'(current_clamp)
                                                             : 16'(alu_res[14:0]);
                cneg  <= num_r[49];
                state <= S_DER;
              end
              SP_DER20: begin cmag <= alu_res[15:0]; state <= S_OUT; end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLOSE: begin
          over_r <= total_r > $signed({24'b0, limit_r, 16'b0});
          k      <= '0;
          state  <= S_LOAD;
        end
        S_LOAD: begin
          cur_r <= current_store[k];
          spd_r <= speed_store[k];
          pw_r  <= wheel_power_store[k];
          cmag  <= abs16(current_store[k]);
          cneg  <= current_store[k][15];
          if (!over_r) begin
            state <= S_OUT;
          end else if (wheel_power_store[k][39] && limit_r != '0) begin
            // negative scaled power skips the solve; the original current is only derated
            state <= S_DER;
          end else begin
            step   <= SP_PROD;
            issued <= 1'b0;
            state  <= S_RUN;
          end
        end
        S_DER: begin
          if (energy_r inside {[8'd20:8'd29]}) begin
            cmag  <= cmag >> 2;
            state <= S_OUT;
          end else if (energy_r inside {[8'd10:8'd19]}) begin
            cmag  <= cmag >> 3;
            state <= S_OUT;
          end else if (energy_r < 8'd10) begin
            step   <= SP_DER20;
            issued <= 1'b0;
            state  <= S_RUN;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            wheel_index     <= 2'(k);
            limited_current <= cneg ? 16'(-cmag) : cmag;
            result_last     <= (k == nlast_r);
            if (k == nlast_r) begin
              wheel_count <= '0;
              total_r     <= '0;
              state       <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_idle_no_op, state == S_IDLE, !issued)
  `ASSERT_NEXT(a_cycle_cleared, state == S_OUT && out_free && k == nlast_r, wheel_count == '0 && total_r == '0)
  `ASSERT_IMPLIES(a_wheel_in_range, state == S_LOAD, k <= nlast_r)

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for wheel_power_limiter_top
// depends on wpl_pkg and the limiter rtl; predicts each wheel's limited current
`timescale 1ns / 100ps

module tb_top;
  import wpl_pkg::*;

  typedef struct packed {
    logic signed [15:0] cur;
    logic signed [15:0] spd;
    logic signed [15:0] scur;
    logic signed [15:0] sspd;
    logic [7:0]         lim;
    logic [7:0]         energy;
    logic               last;
  } wheel_item_t;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [15:0] cur;
    logic               last;
  } limited_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  wheel_item_t tx = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] wheel_index;
  logic signed [15:0] limited_current;
  logic result_last;
  logic cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = CFG_TORQUE;
  logic [CFG_DW-1:0] cfg_data = '0;

  wheel_power_limiter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .drive_current(tx.cur), .drive_speed(tx.spd),
    .steer_current(tx.scur), .steer_speed(tx.sspd),
    .power_limit(tx.lim), .reserve_energy(tx.energy), .wheel_last(tx.last),
    .out_valid(out_valid), .out_ready(out_ready),
    .wheel_index(wheel_index), .limited_current(limited_current),
    .result_last(result_last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state: coefficients and the open control cycle
  longint kt = 2195600, ks = 10236450, ka = 135240, k2 = 159759;
  longint static_pw = 1173, clamp = 16000;
  longint cur_st[4], spd_st[4], pw_st[4];
  longint total_pw = 0;
  int wheel_cnt = 0;

  wheel_item_t pending_wheels[$];
  limited_t expected_currents[$];
  int send_idle = 36, recv_idle = 64;
  bit hold_send = 0;
  int errors = 0;

  // floor square root, result bits 44 down to 0
  function automatic longint floor_root(input logic [127:0] d);
    logic [127:0] r, t;
    r = '0;
    for (int b = 44; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= d) r = t;
    end
    return longint'(r);
  endfunction

  // solve the quadratic for the current that meets the scaled power
  function automatic longint solve_current(input longint cur, input longint spd,
                                           input longint scaled);
    longint a, b, c, s, num, q;
    logic signed [127:0] aw, bw, cw, d;
    a = ka;
    b = kt * spd;
    c = k2 * spd * spd + (static_pw <<< 32) - scaled * 16777216;
    aw = a; bw = b; cw = c;
    d = bw * bw - 4 * aw * cw;
    if (d < 0) d = 0;
    s = floor_root(d);
    num = (cur > 0) ? -b + s : -b - s;
    if (a == 0) q = (num > 0) ? clamp : ((num < 0) ? -clamp : 0);
    else q = num / (2 * a);
    if (q > clamp) q = clamp;
    if (q < -clamp) q = -clamp;
    return q;
  endfunction

  // accumulate one wheel; on cycle close queue the limited currents
  task automatic predict_limited(input wheel_item_t w);
    longint cur, spd, pw, steer, lim16, c, prod;
    int idx, n;
    bit over;
    limited_t r;
    cur = w.cur; spd = w.spd;
    lim16 = longint'(w.lim) <<< 16;
    idx = (wheel_cnt < 4) ? wheel_cnt : 0;
    pw = (kt * cur * spd + k2 * spd * spd + ka * cur * cur + (static_pw <<< 32)) / 16777216;
    steer = (ks * longint'(w.scur) * longint'(w.sspd)) / 16777216;
    cur_st[idx] = cur; spd_st[idx] = spd; pw_st[idx] = pw;
    total_pw += pw + steer;
    if (!w.last && idx + 1 < 4) begin
      wheel_cnt = idx + 1;
      return;
    end
    n = idx + 1;
    over = total_pw > lim16;
    for (int k = 0; k < n; k++) begin
      c = cur_st[k];
      if (over) begin
        prod = pw_st[k] * lim16;
        if (prod >= 0) c = solve_current(c, spd_st[k], prod / total_pw);
        if (w.energy >= 20 && w.energy < 30) c = c / 4;
        else if (w.energy >= 10 && w.energy < 20) c = c / 8;
        else if (w.energy < 10) c = c / 20;
      end
      r.idx = k[1:0];
      r.cur = c[15:0];
      r.last = (k + 1 == n);
      expected_currents.push_back(r);
    end
    total_pw = 0;
    wheel_cnt = 0;
  endtask

  // driver: next wheel from the pending queue
  always @(posedge clk) begin : wheel_driver
    wheel_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_wheels.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
        nxt = pending_wheels.pop_front();
        tx <= nxt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin : current_monitor
    limited_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (in_valid && in_ready) predict_limited(tx);
      if (out_valid && out_ready) begin
        if (expected_currents.size() == 0) begin
          $display("%0t: unexpected result idx=%0d cur=%0d last=%0d", $time,
                   wheel_index, limited_current, result_last);
          errors++;
        end else begin
          want = expected_currents.pop_front();
          if (wheel_index !== want.idx) begin
            $display("%0t: wheel_index expected %0d actual %0d", $time, want.idx, wheel_index);
            errors++;
          end
          if (limited_current !== want.cur) begin
            $display("%0t: limited_current expected %0d actual %0d (wheel %0d)", $time,
                     want.cur, limited_current, want.idx);
            errors++;
          end
          if (result_last !== want.last) begin
            $display("%0t: result_last expected %0d actual %0d", $time, want.last, result_last);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_wheel(input int cur, input int spd, input int scur, input int sspd,
                           input int lim, input int energy, input bit last);
    wheel_item_t w;
    w.cur = cur[15:0]; w.spd = spd[15:0]; w.scur = scur[15:0]; w.sspd = sspd[15:0];
    w.lim = lim[7:0]; w.energy = energy[7:0]; w.last = last;
    pending_wheels.push_back(w);
  endtask

  // random control cycles, mostly well formed with a power limit that bites
  task automatic add_random_cycles(input int count);
    int len, lim, en;
    bit last;
    for (int made = 0; made < count; ) begin
      len = $urandom_range(1, 4);
      lim = ($urandom_range(9) < 7) ? $urandom_range(0, 60) : $urandom_range(0, 255);
      en = ($urandom_range(9) < 8) ? $urandom_range(0, 40) : $urandom_range(0, 255);
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1);
        if (k == 3) last = $urandom_range(1);
        add_wheel(int'($urandom_range(32768)) - 16384, int'($urandom_range(65535)) - 32768,
                  int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                  lim, en, last);
        made++;
      end
    end
  endtask

  // wait for every wheel to transfer and every result to arrive
  task automatic drain();
    while (pending_wheels.size() != 0 || in_valid) @(posedge clk);
    while (expected_currents.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input longint value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[23:0];
    case (idx)
      CFG_TORQUE:     kt = value & 24'hFFFFFF;
      CFG_STEER:      ks = value & 24'hFFFFFF;
      CFG_COPPER:     ka = value & 24'hFFFFFF;
      CFG_SPEED_LOSS: k2 = value & 24'hFFFFFF;
      CFG_STATIC:     static_pw = value & 16'hFFFF;
      CFG_CLAMP:      clamp = value & 15'h7FFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input longint t, input longint s, input longint a,
                           input longint q, input longint st, input longint cl);
    write_reg(CFG_TORQUE, t);
    write_reg(CFG_STEER, s);
    write_reg(CFG_COPPER, a);
    write_reg(CFG_SPEED_LOSS, q);
    write_reg(CFG_STATIC, st);
    write_reg(CFG_CLAMP, cl);
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, energy bands, overflow close, negative power
    add_wheel(16384, 32767, 32767, 32767, 0, 0, 1);
    add_wheel(-16384, -32768, -32768, -32768, 0, 9, 1);
    add_wheel(0, 0, 0, 0, 255, 255, 1);
    add_wheel(16384, -32768, 0, 0, 10, 10, 0);
    add_wheel(-16384, 32767, 100, -100, 10, 19, 1);
    add_wheel(8000, 4000, 1000, 2000, 5, 20, 0);
    add_wheel(-8000, 4000, -1000, 2000, 5, 29, 0);
    add_wheel(12000, 8000, 30000, 30000, 5, 30, 0);
    add_wheel(-12000, -8000, 0, 0, 20, 255, 0);
    add_wheel(1, 1, 1, 1, 0, 0, 0);
    add_wheel(-1, -1, -1, 1, 0, 5, 1);
    add_wheel(16384, 0, 0, 0, 1, 15, 0);
    add_wheel(0, 32767, 0, 0, 1, 25, 1);
    add_wheel(16000, 30000, 0, 0, 255, 0, 1);
    add_wheel(-16000, -30000, 32767, -32768, 255, 0, 1);
    add_random_cycles(80);
    drain();

    // maximum coefficients, sender mostly idle
    send_idle = 64; recv_idle = 36;
    write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16384);
    add_random_cycles(90);
    drain();

    // zero copper coefficient saturates the quotient
    send_idle = 0; recv_idle = 0;
    write_all($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF), 0,
              $urandom_range(24'hFFFFFF), $urandom_range(16'hFFFF), $urandom_range(16384));
    add_random_cycles(45);
    // hold the sender until everything queued so far has come back
    while (pending_wheels.size() != 0 || in_valid) @(posedge clk);
    hold_send = 1;
    add_random_cycles(45);
    while (expected_currents.size() != 0) @(posedge clk);
    hold_send = 0;
    drain();

    // zero torque, steer, speed loss, static and clamp, then random coefficients
    write_all(0, 0, $urandom_range(1, 24'hFFFFFF), 0, 0, 0);
    add_random_cycles(40);
    drain();
    write_all($urandom_range(24'hFFFFFF), $urandom_range(24'hFFFFFF),
              $urandom_range(1, 24'hFFFFFF), $urandom_range(24'hFFFFFF),
              $urandom_range(16'hFFFF), $urandom_range(16384));
    add_random_cycles(60);
    drain();

    if (errors == 0) begin
      $display("wheel_power_limiter_top verification clean");
    end else begin
      $display("wheel_power_limiter_top verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("wheel_power_limiter_top verification failed");
    $finish;
  end

endmodule
